FILE: design/olvd_pkg.sv
// Shared types, codes and sizes for the ordered list with value delete.
// Used by olvd_cell, olvd_ctrl and ordered_list_with_value_delete_top.
`timescale 1ns / 1ps

package olvd_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_INSERT    = 3'd0;
    localparam kind_t KIND_DISPLAY   = 3'd1;
    localparam kind_t KIND_DEL_HEAD  = 3'd2;
    localparam kind_t KIND_DEL_TAIL  = 3'd3;
    localparam kind_t KIND_DEL_VALUE = 3'd4;

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_EMPTY     = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;
    localparam status_t STATUS_FULL      = 2'd3;

    typedef logic [1:0] cell_cmd_t;
    localparam cell_cmd_t CMD_HOLD = 2'd0;
    localparam cell_cmd_t CMD_LOAD = 2'd1;
    localparam cell_cmd_t CMD_ROT  = 2'd2;
    localparam cell_cmd_t CMD_DROP = 2'd3;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [DATA_W-1:0]  operand;
    } cell_ctl_t;

endpackage

FILE: design/olvd_cell.sv
// One storage cell of the list chain: holds the entry at one list position.
// Depends on olvd_pkg for the command codes and the control struct.
`timescale 1ns / 1ps

module olvd_cell (
    input  logic                               aclk,
    input  olvd_pkg::cell_ctl_t                ctl,
    input  logic                               load_sel,
    input  logic                               wrap_sel,
    input  logic signed [olvd_pkg::DATA_W-1:0] head_data,
    input  logic signed [olvd_pkg::DATA_W-1:0] right_data,
    output logic signed [olvd_pkg::DATA_W-1:0] data
);

    logic signed [olvd_pkg::DATA_W-1:0] data_reg;
    logic signed [olvd_pkg::DATA_W-1:0] data_next;

    // A rotate moves every entry one place toward the head; the tail cell
    // takes the old head so the occupied part of the chain forms a ring.
    always_comb begin
        data_next = data_reg;
        case (ctl.cmd)
            olvd_pkg::CMD_LOAD: begin
                if (load_sel) begin
                    data_next = ctl.operand;
                end
            end
            olvd_pkg::CMD_ROT: begin
                data_next = wrap_sel ? head_data : right_data;
            end
            olvd_pkg::CMD_DROP: begin
                data_next = right_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

FILE: design/olvd_ctrl.sv
// Sequencer for the list: takes requests, drives the cell chain commands
// and holds the result register. Depends on olvd_pkg.
`timescale 1ns / 1ps

module olvd_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  olvd_pkg::kind_t                    s_kind,
    input  logic signed [olvd_pkg::DATA_W-1:0] s_operand_value,
    input  logic signed [olvd_pkg::DATA_W-1:0] head_data,
    output olvd_pkg::cell_ctl_t                cell_ctl,
    output logic [olvd_pkg::CAPACITY-1:0]      load_sel,
    output logic [olvd_pkg::CAPACITY-1:0]      wrap_sel,
    output logic [olvd_pkg::CNT_W-1:0]         entry_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output olvd_pkg::status_t                  m_status,
    output logic signed [olvd_pkg::DATA_W-1:0] m_entry_value,
    output logic                               m_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                               state_reg, state_next;
    logic [olvd_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [olvd_pkg::CNT_W-1:0]         steps_reg, steps_next;
    olvd_pkg::kind_t                    kind_reg, kind_next;
    logic signed [olvd_pkg::DATA_W-1:0] operand_reg, operand_next;
    logic                               found_reg, found_next;
    logic                               special_reg, special_next;
    olvd_pkg::status_t                  sp_status_reg, sp_status_next;
    logic                               sp_zero_reg, sp_zero_next;
    logic                               m_valid_reg, m_valid_next;
    olvd_pkg::status_t                  m_status_reg, m_status_next;
    logic signed [olvd_pkg::DATA_W-1:0] m_value_reg, m_value_next;
    logic                               m_last_reg, m_last_next;

    logic      out_free;
    logic      last_step;
    logic      is_empty;
    logic      is_full;
    logic      match;
    olvd_pkg::cell_cmd_t cmd;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (steps_reg == olvd_pkg::CNT_W'(1));
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg == olvd_pkg::CNT_W'(olvd_pkg::CAPACITY));
    assign match     = (head_data == operand_reg);

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        steps_next     = steps_reg;
        kind_next      = kind_reg;
        operand_next   = operand_reg;
        found_next     = found_reg;
        special_next   = special_reg;
        sp_status_next = sp_status_reg;
        sp_zero_next   = sp_zero_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_value_next   = m_value_reg;
        m_last_next    = m_last_reg;
        cmd            = olvd_pkg::CMD_HOLD;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (state_reg == ST_IDLE) begin
            // Unused kind codes are taken and dropped without a result.
            if (s_valid && (s_kind inside {[olvd_pkg::KIND_INSERT:olvd_pkg::KIND_DEL_VALUE]}))
            begin
                state_next     = ST_RUN;
                kind_next      = s_kind;
                operand_next   = s_operand_value;
                found_next     = 1'b0;
                special_next   = is_empty;
                sp_status_next = olvd_pkg::STATUS_EMPTY;
                sp_zero_next   = 1'b1;
                steps_next     = is_empty ? olvd_pkg::CNT_W'(1) : count_reg;
                case (s_kind)
                    olvd_pkg::KIND_INSERT: begin
                        steps_next     = olvd_pkg::CNT_W'(1);
                        special_next   = is_full;
                        sp_status_next = olvd_pkg::STATUS_FULL;
                        sp_zero_next   = 1'b0;
                    end
                    olvd_pkg::KIND_DEL_HEAD: begin
                        steps_next = olvd_pkg::CNT_W'(1);
                    end
                    olvd_pkg::KIND_DEL_VALUE: begin
                        sp_zero_next = 1'b0;
                    end
                    default: begin
                        sp_zero_next = 1'b1;
                    end
                endcase
            end
        end else if (out_free) begin
            steps_next    = steps_reg - olvd_pkg::CNT_W'(1);
            m_status_next = olvd_pkg::STATUS_OK;
            m_value_next  = operand_reg;
            m_last_next   = 1'b1;
            if (last_step) begin
                state_next = ST_IDLE;
            end
            if (special_reg) begin
                m_valid_next  = 1'b1;
                m_status_next = sp_status_reg;
                m_value_next  = sp_zero_reg ? '0 : operand_reg;
            end else begin
                case (kind_reg)
                    olvd_pkg::KIND_INSERT: begin
                        cmd          = olvd_pkg::CMD_LOAD;
                        count_next   = count_reg + olvd_pkg::CNT_W'(1);
                        m_valid_next = 1'b1;
                    end
                    olvd_pkg::KIND_DISPLAY: begin
                        cmd          = olvd_pkg::CMD_ROT;
                        m_valid_next = 1'b1;
                        m_value_next = head_data;
                        m_last_next  = last_step;
                    end
                    olvd_pkg::KIND_DEL_HEAD: begin
                        cmd          = olvd_pkg::CMD_DROP;
                        count_next   = count_reg - olvd_pkg::CNT_W'(1);
                        m_valid_next = 1'b1;
                        m_value_next = head_data;
                    end
                    olvd_pkg::KIND_DEL_TAIL: begin
                        // The tail reaches the head after count-1 rotations.
                        if (last_step) begin
                            cmd          = olvd_pkg::CMD_DROP;
                            count_next   = count_reg - olvd_pkg::CNT_W'(1);
                            m_valid_next = 1'b1;
                            m_value_next = head_data;
                        end else begin
                            cmd = olvd_pkg::CMD_ROT;
                        end
                    end
                    olvd_pkg::KIND_DEL_VALUE: begin
                        // The first match is dropped in place; the walk keeps
                        // rotating so the list ends back in its original order.
                        if (match && !found_reg) begin
                            cmd        = olvd_pkg::CMD_DROP;
                            count_next = count_reg - olvd_pkg::CNT_W'(1);
                            found_next = 1'b1;
                        end else begin
                            cmd = olvd_pkg::CMD_ROT;
                        end
                        if (last_step) begin
                            m_valid_next  = 1'b1;
                            m_status_next = (found_reg || match) ? olvd_pkg::STATUS_OK
                                                                 : olvd_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    default: begin
                        cmd = olvd_pkg::CMD_HOLD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        steps_reg     <= steps_next;
        kind_reg      <= kind_next;
        operand_reg   <= operand_next;
        found_reg     <= found_next;
        special_reg   <= special_next;
        sp_status_reg <= sp_status_next;
        sp_zero_reg   <= sp_zero_next;
        m_status_reg  <= m_status_next;
        m_value_reg   <= m_value_next;
        m_last_reg    <= m_last_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < olvd_pkg::CAPACITY; gi++) begin : g_sel
            assign load_sel[gi] = (count_reg == olvd_pkg::CNT_W'(gi));
            assign wrap_sel[gi] = (count_reg == olvd_pkg::CNT_W'(gi + 1));
        end
    endgenerate

    assign s_ready          = (state_reg == ST_IDLE);
    assign cell_ctl.cmd     = cmd;
    assign cell_ctl.operand = operand_reg;
    assign entry_count      = count_reg;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_entry_value    = m_value_reg;
    assign m_last           = m_last_reg;

endmodule

FILE: design/ordered_list_with_value_delete_top.sv
// Ordered list of signed 32-bit values, up to 16 entries, kept in a chain of
// cells where cell 0 always holds the head. A request is taken while the
// block is idle and then runs one step per cycle: insert and delete head
// take one step; display, delete tail and delete value take one step per
// stored entry, because the chain rotates the list past the head cell once.
// Any request on an empty list takes one step. A request with an unused
// kind code is taken and dropped. A step waits while the result register
// holds a result that has not been taken. Display gives one result per
// entry, or one on an empty list; every other request gives one result.
// Unused kind codes give no result.
// Depends on olvd_pkg, olvd_ctrl and olvd_cell.
`timescale 1ns / 1ps

module ordered_list_with_value_delete_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_kind,
    input  logic signed [31:0]                 s_operand_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic signed [31:0]                 m_entry_value,
    output logic                               m_last
);

    olvd_pkg::cell_ctl_t                cell_ctl;
    logic [olvd_pkg::CAPACITY-1:0]      load_sel;
    logic [olvd_pkg::CAPACITY-1:0]      wrap_sel;
    logic [olvd_pkg::CNT_W-1:0]         entry_count;
    logic signed [olvd_pkg::DATA_W-1:0] cell_data [olvd_pkg::CAPACITY];

    olvd_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_operand_value (s_operand_value),
        .head_data       (cell_data[0]),
        .cell_ctl        (cell_ctl),
        .load_sel        (load_sel),
        .wrap_sel        (wrap_sel),
        .entry_count     (entry_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_entry_value   (m_entry_value),
        .m_last          (m_last)
    );

    genvar gi;
    generate
        for (gi = 0; gi < olvd_pkg::CAPACITY; gi++) begin : g_cell
            logic signed [olvd_pkg::DATA_W-1:0] right_data;
            if (gi == olvd_pkg::CAPACITY - 1) begin : g_end
                assign right_data = cell_data[0];
            end else begin : g_mid
                assign right_data = cell_data[gi + 1];
            end
            olvd_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl),
                .load_sel   (load_sel[gi]),
                .wrap_sel   (wrap_sel[gi]),
                .head_data  (cell_data[0]),
                .right_data (right_data),
                .data       (cell_data[gi])
            );
        end
    endgenerate

`ifndef SYNTH
    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_count <= olvd_pkg::CNT_W'(olvd_pkg::CAPACITY))
        else $error("entry count above capacity");

    // The count moves by at most one entry per cycle.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (entry_count == $past(entry_count) ||
                  entry_count == $past(entry_count) + olvd_pkg::CNT_W'(1) ||
                  entry_count == $past(entry_count) - olvd_pkg::CNT_W'(1)))
        else $error("entry count jumped");

    // Entries leave the list only through a drop of the chain.
    a_shrink_by_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (entry_count >= $past(entry_count) ||
                  $past(cell_ctl.cmd) == olvd_pkg::CMD_DROP))
        else $error("entry count fell without a drop");
`endif

endmodule

FILE: bench/tb.sv
// Self-checking testbench for ordered_list_with_value_delete_top: a scoreboard class
// predicts each request's results; a plain task drives the request channel and an initial block drives m_ready.
// Depends on olvd_pkg and the design files.
`timescale 1ns / 1ps

import olvd_pkg::*;

typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] value;
    logic                     last;
} list_result_t;

class list_scoreboard;
    logic signed [DATA_W-1:0] held[$];     // predicted list contents, head first
    list_result_t             awaited[$];  // predicted results not yet seen
    int errors;
    int requests;
    int ignored;
    int checked;
    int full_rejects;
    int empty_hits;
    int misses;

    function void queue_result(status_t status, logic signed [DATA_W-1:0] value, logic last);
        list_result_t r;
        r.status = status;
        r.value  = value;
        r.last   = last;
        awaited.push_back(r);
        if (status == STATUS_FULL)
            full_rejects++;
        if (status == STATUS_EMPTY)
            empty_hits++;
        if (status == STATUS_NOT_FOUND)
            misses++;
    endfunction

    function void note_request(kind_t kind, logic signed [DATA_W-1:0] operand);
        int pos;
        requests++;
        case (kind)
            KIND_INSERT: begin
                if (held.size() >= CAPACITY) begin
                    queue_result(STATUS_FULL, operand, 1'b1);
                end else begin
                    held.push_back(operand);
                    queue_result(STATUS_OK, operand, 1'b1);
                end
            end
            KIND_DISPLAY: begin
                if (held.size() == 0)
                    queue_result(STATUS_EMPTY, '0, 1'b1);
                else
                    foreach (held[i])
                        queue_result(STATUS_OK, held[i], i == held.size() - 1);
            end
            KIND_DEL_HEAD: begin
                if (held.size() == 0)
                    queue_result(STATUS_EMPTY, '0, 1'b1);
                else
                    queue_result(STATUS_OK, held.pop_front(), 1'b1);
            end
            KIND_DEL_TAIL: begin
                if (held.size() == 0)
                    queue_result(STATUS_EMPTY, '0, 1'b1);
                else
                    queue_result(STATUS_OK, held.pop_back(), 1'b1);
            end
            KIND_DEL_VALUE: begin
                if (held.size() == 0) begin
                    queue_result(STATUS_EMPTY, operand, 1'b1);
                end else begin
                    // Only the first match counting from the head is removed.
                    pos = -1;
                    for (int i = 0; i < held.size(); i++) begin
                        if (held[i] == operand) begin
                            pos = i;
                            break;
                        end
                    end
                    if (pos < 0) begin
                        queue_result(STATUS_NOT_FOUND, operand, 1'b1);
                    end else begin
                        held.delete(pos);
                        queue_result(STATUS_OK, operand, 1'b1);
                    end
                end
            end
            default: begin
                ignored++;
            end
        endcase
    endfunction

    function void check_result(status_t status, logic signed [DATA_W-1:0] value, logic last);
        list_result_t want;
        if (awaited.size() == 0) begin
            $error("unexpected result: status %0d, entry_value %0d, last %0b",
                   status, value, last);
            errors++;
            return;
        end
        want = awaited.pop_front();
        checked++;
        if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
        end
        if (value !== want.value) begin
            $error("entry_value: expected %0d, got %0d", want.value, value);
            errors++;
        end
        if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function logic signed [DATA_W-1:0] any_entry();
        return held[$urandom_range(0, held.size() - 1)];
    endfunction
endclass

module tb;

    localparam int RANDOM_REQUESTS = 95;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 200000;

    localparam int PHASE_FILL  = 0;
    localparam int PHASE_DRAIN = 1;
    localparam int PHASE_MIXED = 2;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [2:0]                 s_kind;
    logic signed [DATA_W-1:0]   s_operand_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [1:0]                 m_status;
    logic signed [DATA_W-1:0]   m_entry_value;
    logic                       m_last;

    list_scoreboard sb;
    int             burst_left = 0;
    int             cycles = 0;
    bit             held_off = 1'b0;

    ordered_list_with_value_delete_top uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_operand_value (s_operand_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_entry_value   (m_entry_value),
        .m_last          (m_last)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_entry_value, m_last);
    end

    // Result side: ready stretches of varying density, plus one long hold-off
    // that lets the block fill up and push back on the request side.
    initial begin
        int mode;
        int len;
        m_ready <= 1'b0;
        wait (aresetn);
        forever begin
            if (!held_off && sb.checked >= HOLD_OFF_AFTER) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                mode = $urandom_range(0, 2);
                len  = $urandom_range(4, 40);
                repeat (len) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= ($urandom_range(0, 3) != 0);
                        default: m_ready <= $urandom_range(0, 1);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    task automatic send_request(input kind_t kind, input logic signed [DATA_W-1:0] operand);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid         <= 1'b1;
        s_kind          <= kind;
        s_operand_value <= operand;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(kind, operand);
        burst_left--;
    endtask

    function automatic logic signed [DATA_W-1:0] random_operand();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2, 3, 4, 5: begin
                // A narrow range makes duplicate entries common.
                v = $urandom_range(0, 6);
                v = v - 3;
            end
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic kind_t pick_kind(int phase);
        int roll;
        int t_ins;
        int t_disp;
        int t_head;
        int t_tail;
        roll = $urandom_range(0, 99);
        case (phase)
            PHASE_FILL:  begin t_ins = 80; t_disp = 88; t_head = 92; t_tail = 96; end
            PHASE_DRAIN: begin t_ins = 10; t_disp = 20; t_head = 45; t_tail = 70; end
            default:     begin t_ins = 35; t_disp = 50; t_head = 62; t_tail = 74; end
        endcase
        if (roll < t_ins)
            return KIND_INSERT;
        if (roll < t_disp)
            return KIND_DISPLAY;
        if (roll < t_head)
            return KIND_DEL_HEAD;
        if (roll < t_tail)
            return KIND_DEL_TAIL;
        return KIND_DEL_VALUE;
    endfunction

    initial begin
        int random_left;
        int phase;
        int steps;
        bit first_phase;
        kind_t kind;
        logic signed [DATA_W-1:0] operand;

        sb = new();
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_kind          <= KIND_INSERT;
        s_operand_value <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every operation but insert on an empty list.
        send_request(KIND_DISPLAY, 32'sd0);
        send_request(KIND_DEL_HEAD, 32'sd0);
        send_request(KIND_DEL_TAIL, 32'sd0);
        send_request(KIND_DEL_VALUE, 32'sh7fff_ffff);
        // Extreme values, with a duplicate zero.
        send_request(KIND_INSERT, 32'sh7fff_ffff);
        send_request(KIND_INSERT, 32'sh8000_0000);
        send_request(KIND_INSERT, 32'sd0);
        send_request(KIND_INSERT, -32'sd1);
        send_request(KIND_INSERT, 32'sd5);
        send_request(KIND_INSERT, 32'sd0);
        send_request(KIND_DISPLAY, 32'sd0);
        // Value deletes from the middle, a miss, then at the head and again in the middle.
        send_request(KIND_DEL_VALUE, 32'sd0);
        send_request(KIND_DEL_VALUE, 32'sd12345);
        send_request(KIND_DEL_VALUE, 32'sh7fff_ffff);
        send_request(KIND_DEL_VALUE, 32'sd5);
        send_request(KIND_DISPLAY, 32'sd0);
        send_request(KIND_DEL_TAIL, 32'sd0);
        send_request(KIND_DEL_HEAD, 32'sd0);
        send_request(KIND_DEL_HEAD, 32'sd0);
        // Unused codes must leave the list alone.
        send_request(3'd5, 32'sh5555_5555);
        send_request(3'd6, 32'shaaaa_aaaa);
        send_request(3'd7, -32'sd1);
        send_request(KIND_DISPLAY, 32'sd0);

        // Random phases that swing the list between full and empty.
        random_left = RANDOM_REQUESTS;
        first_phase = 1'b1;
        while (random_left > 0) begin
            phase = first_phase ? PHASE_FILL : $urandom_range(PHASE_FILL, PHASE_MIXED);
            first_phase = 1'b0;
            case (phase)
                PHASE_FILL:  steps = CAPACITY - sb.held.size() + $urandom_range(2, 5);
                PHASE_DRAIN: steps = sb.held.size() + $urandom_range(1, 3);
                default:     steps = $urandom_range(6, 20);
            endcase
            repeat (steps) begin
                if ($urandom_range(0, 99) < 5) begin
                    send_request(kind_t'($urandom_range(5, 7)), $urandom());
                end else begin
                    kind = pick_kind(phase);
                    if (kind == KIND_DEL_VALUE && sb.held.size() != 0
                            && $urandom_range(0, 9) < 7)
                        operand = sb.any_entry();
                    else
                        operand = random_operand();
                    send_request(kind, operand);
                    random_left--;
                end
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d requests (%0d with unused codes) and checked %0d results.",
                 sb.requests, sb.ignored, sb.checked);
        $display("Saw %0d inserts rejected as full, %0d empty-list replies, %0d misses.",
                 sb.full_rejects, sb.empty_hits, sb.misses);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
